@@ hw/rtl/pid_pkg.sv @@
// shared types, register indexes, sequencer codes and fixed-point helpers
// for the clamped pid controller; no dependencies
package pid_pkg;

  typedef logic signed [31:0] q16_t;   // signed q16.16
  typedef logic signed [32:0] err_t;   // signed q17.16
  typedef logic [30:0]        ureg_t;  // unsigned q15.16 register

  typedef enum logic [2:0] {
    REG_SET_POINT = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_OUT_MIN   = 3'd4,
    REG_OUT_MAX   = 3'd5,
    REG_PERIOD    = 3'd6,
    REG_TOLERANCE = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_POST,
    S_DIV,
    S_DEND,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    TERM_INT,
    TERM_P,
    TERM_I,
    TERM_D
  } term_e;

  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  // magnitude plus sign to 32-bit signed, saturating
  function automatic q16_t sat32(logic [63:0] mag, logic neg);
    q16_t res;
    if (!neg) begin
      res = (mag > 64'h7FFF_FFFF) ? Q16_MAX : q16_t'(mag[31:0]);
    end else if (mag > 64'h8000_0000) begin
      res = Q16_MIN;
    end else begin
      res = q16_t'(~mag[31:0] + 32'd1);
    end
    return res;
  endfunction

  // upper limit tested first: crossed limits give hi above hi, else lo
  function automatic q16_t clamp32(logic signed [33:0] x, q16_t lo, q16_t hi);
    q16_t res;
    if (x > 34'(hi)) begin
      res = hi;
    end else if (x < 34'(lo)) begin
      res = lo;
    end else begin
      res = q16_t'(x[31:0]);
    end
    return res;
  endfunction

  function automatic logic [33:0] abs34(logic signed [33:0] x);
    return x[33] ? (~x + 34'd1) : x;
  endfunction

endpackage

@@ hw/rtl/pid_if.sv @@
// valid/ready stream interfaces for the measurement and result channels
// depends on pid_pkg
interface pid_meas_if;
  import pid_pkg::*;
  logic valid;
  logic ready;
  q16_t measured;
  modport source (output valid, output measured, input ready);
  modport sink (input valid, input measured, output ready);
endinterface

interface pid_res_if;
  import pid_pkg::*;
  logic valid;
  logic ready;
  q16_t drive;
  err_t error_value;
  logic steady;
  modport source (output valid, output drive, output error_value, output steady,
                  input ready);
  modport sink (input valid, input drive, input error_value, input steady,
                output ready);
endinterface

@@ hw/rtl/pid_controller_clamped_top.sv @@
// clamped pid controller in signed q16.16, one shared multiply/divide datapath
// depends on pid_pkg and the stream interfaces in pid_if
//
//  - meas_i carries one measured value per transfer; res_o returns one
//    result (drive, error_value, steady) per measurement, in order
//  - configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i),
//    register i of the list at index i; write only while the block is idle
//  - meas_i.ready is high only while the sequencer is idle, so one
//    measurement is in flight at a time
//  - each transfer runs four products through one 34x16 multiplier and
//    64-bit adder, two passes each plus setup and post steps, then the
//    derivative quotient (restoring divide steps, one per quotient bit,
//    and an add), skipped when it saturates, and one final step that
//    raises res_o.valid; the next transfer can follow in the cycle after
//    the final step
//  - the result sits in an output register; the next measurement is taken
//    while it waits, and the sequencer holds in its last step only if the
//    register is still full when the next result is ready
//  - reset (rst_ni low, async) clears the integral, the stored error and
//    the output valid, and loads the register defaults
module pid_controller_clamped_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  pid_pkg::cfg_reg_e  cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  pid_meas_if.sink           meas_i,
  pid_res_if.source          res_o
);
  import pid_pkg::*;

  // configuration registers
  q16_t  sp_q, omin_q, omax_q;
  ureg_t kp_q, ki_q, kd_q, per_q, tol_q;

  // controller state
  q16_t integral_q, integral_d;
  err_t prev_q, prev_d;

  // sequencer and datapath
  state_e state_q, state_d;
  term_e  term_q, term_d;
  err_t   err_q, err_d;
  logic [33:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [63:0] acc_q, acc_d;
  logic        chunk_q, chunk_d;
  logic [30:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic signed [33:0] sum_q, sum_d;

  // output register
  logic rvalid_q, rvalid_d;
  q16_t drive_q, drive_d;
  err_t eout_q, eout_d;
  logic steady_q, steady_d;

  // shared unit signals
  ureg_t       gain_sel;
  logic [15:0] gain_chunk;
  logic [49:0] part;
  logic [63:0] addend;
  q16_t        term_val;
  logic signed [33:0] diff;
  logic [31:0] div_sh;
  logic        div_ge;
  logic        dsat;
  logic        out_free;

  // config writes, bits above a register's width dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= '0;
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      omin_q <= Q16_MIN;
      omax_q <= Q16_MAX;
      per_q  <= 31'd65536;
      tol_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SET_POINT: sp_q   <= q16_t'(cfg_data_i);
        REG_GAIN_P:    kp_q   <= cfg_data_i[30:0];
        REG_GAIN_I:    ki_q   <= cfg_data_i[30:0];
        REG_GAIN_D:    kd_q   <= cfg_data_i[30:0];
        REG_OUT_MIN:   omin_q <= q16_t'(cfg_data_i);
        REG_OUT_MAX:   omax_q <= q16_t'(cfg_data_i);
        REG_PERIOD:    per_q  <= cfg_data_i[30:0];
        REG_TOLERANCE: tol_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // gain for the product in progress, taken 16 bits per pass
  always_comb begin
    case (term_q)
      TERM_INT: gain_sel = per_q;
      TERM_P:   gain_sel = kp_q;
      TERM_I:   gain_sel = ki_q;
      TERM_D:   gain_sel = kd_q;
      default:  gain_sel = '0;
    endcase
  end

  assign gain_chunk = chunk_q ? {1'b0, gain_sel[30:16]} : gain_sel[15:0];
  assign part       = 50'(mag_q) * 50'(gain_chunk);
  assign addend     = chunk_q ? 64'({part, 16'h0000}) : 64'(part);

  // product with q16 fraction dropped, then saturated
  assign term_val = sat32({16'h0000, acc_q[63:16]}, neg_q);

  assign diff = 34'(err_q) - 34'(prev_q);

  // derivative quotient of 2^32 or more, or a zero period
  assign dsat = (acc_q >= {1'b0, per_q, 32'h0000_0000});

  // restoring divide step
  assign div_sh = {rem_q, acc_q[31]};
  assign div_ge = (div_sh >= {1'b0, per_q});

  assign out_free = !rvalid_q || res_o.ready;

  always_comb begin
    state_d    = state_q;
    term_d     = term_q;
    err_d      = err_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    chunk_d    = chunk_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    integral_d = integral_q;
    prev_d     = prev_q;
    drive_d    = drive_q;
    eout_d     = eout_q;
    steady_d   = steady_q;
    rvalid_d   = rvalid_q && !res_o.ready;

    case (state_q)
      S_IDLE: begin
        if (meas_i.valid) begin
          err_d   = 33'(sp_q) - 33'(meas_i.measured);
          term_d  = TERM_INT;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        case (term_q)
          TERM_I: begin
            mag_d = abs34(34'(integral_q));
            neg_d = integral_q[31];
          end
          TERM_D: begin
            mag_d = abs34(diff);
            neg_d = diff[33];
          end
          default: begin
            mag_d = abs34(34'(err_q));
            neg_d = err_q[32];
          end
        endcase
        acc_d   = '0;
        chunk_d = 1'b0;
        state_d = S_MUL;
      end
      S_MUL: begin
        acc_d   = acc_q + addend;
        chunk_d = !chunk_q;
        if (chunk_q) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        case (term_q)
          TERM_INT: begin
            integral_d = clamp32(34'(integral_q) + 34'(term_val), omin_q, omax_q);
            term_d     = TERM_P;
            state_d    = S_SETUP;
          end
          TERM_P: begin
            sum_d   = 34'(term_val);
            term_d  = TERM_I;
            state_d = S_SETUP;
          end
          TERM_I: begin
            sum_d   = sum_q + 34'(term_val);
            term_d  = TERM_D;
            state_d = S_SETUP;
          end
          default: begin
            if (dsat) begin
              // zero numerator gives zero even with a zero period
              if (acc_q != 64'd0) begin
                sum_d = sum_q + 34'(sat32('1, neg_q));
              end
              state_d = S_FIN;
            end else begin
              rem_d   = acc_q[62:32];
              cnt_d   = '1;
              state_d = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        rem_d = div_ge ? 31'(div_sh - {1'b0, per_q}) : div_sh[30:0];
        acc_d = {acc_q[63:32], acc_q[30:0], div_ge};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = S_DEND;
        end
      end
      S_DEND: begin
        sum_d   = sum_q + 34'(sat32({32'h0000_0000, acc_q[31:0]}, neg_q));
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          drive_d  = clamp32(sum_q, omin_q, omax_q);
          eout_d   = err_q;
          steady_d = (abs34(34'(err_q)) < {3'b000, tol_q});
          rvalid_d = 1'b1;
          prev_d   = err_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      term_q     <= TERM_INT;
      integral_q <= '0;
      prev_q     <= '0;
      rvalid_q   <= 1'b0;
      err_q      <= '0;
      chunk_q    <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      term_q     <= term_d;
      integral_q <= integral_d;
      prev_q     <= prev_d;
      rvalid_q   <= rvalid_d;
      err_q      <= err_d;
      chunk_q    <= chunk_d;
      cnt_q      <= cnt_d;
    end
  end

  // datapath payload, no reset
  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    sum_q    <= sum_d;
    drive_q  <= drive_d;
    eout_q   <= eout_d;
    steady_q <= steady_d;
  end

  assign meas_i.ready      = (state_q == S_IDLE);
  assign res_o.valid       = rvalid_q;
  assign res_o.drive       = drive_q;
  assign res_o.error_value = eout_q;
  assign res_o.steady      = steady_q;

  // one measurement in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_i.valid && meas_i.ready |=> !meas_i.ready)
    else $error("measurement taken while busy");

  // divider remainder stays below the period
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < per_q)
    else $error("divider remainder out of range");

  // a new result only ever comes from the final step
  a_res_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rvalid_q) |-> $past(state_q) == S_FIN)
    else $error("result raised outside final step");

endmodule

@@ sim/pid_control_checker.sv @@
// scoreboard for the clamped pid controller: follows the register port and both
// stream channels, predicts each result at the measurement transfer and compares it
// depends on pid_pkg and the stream interfaces in pid_if
module pid_control_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  pid_pkg::cfg_reg_e cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  pid_meas_if               meas,
  pid_res_if                res,
  output int                pending_o,
  output int                errors_o,
  output int                results_o,
  output int                steady_o,
  output int                clamped_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pid_pkg::*;

  localparam longint S32_HI = 64'sh7FFF_FFFF;
  localparam longint S32_LO = -64'sh8000_0000;

  typedef struct packed {
    q16_t drive;
    err_t error_value;
    logic steady;
  } control_out_t;

  control_out_t expected_q[$];

  q16_t   set_point_r;
  ureg_t  gain_p_r, gain_i_r, gain_d_r;
  q16_t   low_lim_r, high_lim_r;
  ureg_t  period_r, tol_r;
  q16_t   integral_r;
  longint last_err_r;
  int     errors_n, results_n, steady_n, clamped_n;

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat_signed32(logic [63:0] mag, logic neg);
    if (!neg) return (mag > 64'h7FFF_FFFF) ? S32_HI : longint'(mag);
    if (mag > 64'h8000_0000) return S32_LO;
    return -longint'(mag);
  endfunction

  // q16.16 product: exact magnitude, fraction truncated, then saturated
  function automatic longint fixed_mul(longint v, ureg_t g);
    return sat_signed32((abs64(v) * {33'd0, g}) >> 16, v < 0);
  endfunction

  // upper limit first, so crossed limits give out_max above it and out_min otherwise
  function automatic longint band_limit(longint x);
    if (x > longint'(high_lim_r)) return longint'(high_lim_r);
    if (x < longint'(low_lim_r)) return longint'(low_lim_r);
    return x;
  endfunction

  // one control step; updates the integral and the stored error
  function automatic control_out_t advance_loop(q16_t sample);
    longint       err, diff, d_term, total;
    logic [63:0]  d_mag;
    control_out_t r;
    err = longint'(set_point_r) - longint'(sample);
    integral_r = q16_t'(band_limit(longint'(integral_r) + fixed_mul(err, period_r)));
    diff = err - last_err_r;
    d_mag = abs64(diff) * {33'd0, gain_d_r};
    if (period_r == '0) begin
      if (d_mag == 0) d_term = 0;
      else d_term = (diff < 0) ? S32_LO : S32_HI;
    end else begin
      d_term = sat_signed32(d_mag / {33'd0, period_r}, diff < 0);
    end
    total = fixed_mul(err, gain_p_r) + fixed_mul(longint'(integral_r), gain_i_r) + d_term;
    if (total > longint'(high_lim_r) || total < longint'(low_lim_r)) clamped_n++;
    r.drive = q16_t'(band_limit(total));
    r.error_value = err_t'(err);
    r.steady = abs64(err) < {33'd0, tol_r};
    last_err_r = err;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
    if (got !== want) begin
      errors_n++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    control_out_t want;
    if (!rst_ni) begin
      set_point_r = '0;
      gain_p_r = '0;
      gain_i_r = '0;
      gain_d_r = '0;
      low_lim_r = Q16_MIN;
      high_lim_r = Q16_MAX;
      period_r = 31'd65536;
      tol_r = '0;
      integral_r = '0;
      last_err_r = 0;
      expected_q.delete();
      errors_n = 0;
      results_n = 0;
      steady_n = 0;
      clamped_n = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SET_POINT: set_point_r = q16_t'(cfg_data_i);
          REG_GAIN_P:    gain_p_r = cfg_data_i[30:0];
          REG_GAIN_I:    gain_i_r = cfg_data_i[30:0];
          REG_GAIN_D:    gain_d_r = cfg_data_i[30:0];
          REG_OUT_MIN:   low_lim_r = q16_t'(cfg_data_i);
          REG_OUT_MAX:   high_lim_r = q16_t'(cfg_data_i);
          REG_PERIOD:    period_r = cfg_data_i[30:0];
          REG_TOLERANCE: tol_r = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        results_n++;
        if (expected_q.size() == 0) begin
          errors_n++;
          $display("%0t: result with none expected, expected nothing, actual drive %0d",
                   $time, res.drive);
        end else begin
          want = expected_q.pop_front();
          check_field("drive", want.drive, res.drive);
          check_field("error_value", want.error_value, res.error_value);
          check_field("steady", want.steady, res.steady);
        end
      end
      if (meas.valid && meas.ready) begin
        want = advance_loop(meas.measured);
        if (want.steady) steady_n++;
        expected_q.push_back(want);
      end
    end
    pending_o <= expected_q.size();
    errors_o  <= errors_n;
    results_o <= results_n;
    steady_o  <= steady_n;
    clamped_o <= clamped_n;
  end

endmodule

@@ sim/tb_pid_controller_clamped_top.sv @@
// top-level bench for the clamped pid controller: directed corner items, then
// random register settings with random measurements, gaps and result stalls
// depends on pid_pkg, pid_if, the controller rtl and pid_control_checker
module tb_pid_controller_clamped_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pid_pkg::*;

  localparam int     CLK_HALF = 6;
  localparam int     ITEM_TARGET = 1650;
  // a bit more than the worst item latency of the block
  localparam int     SETTLE_CYCLES = 64;
  localparam longint Q_HI = 64'sh7FFF_FFFF;
  localparam longint Q_LO = -64'sh8000_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_reg_e    cfg_idx_i;
  logic [31:0] cfg_data_i;

  pid_meas_if meas_if ();
  pid_res_if  res_if ();

  int pending_n, errors_n, results_n, steady_n, clamped_n;
  int measures_sent;
  int settings_used;
  // per-phase switches for stretches with no idling on either side
  bit no_meas_gaps;
  bit no_res_stalls;
  // register words of the setting about to be loaded, by register index
  logic [31:0] reg_word [8];
  // set point now in force, so measurements can be steered near it
  q16_t target_now;

  pid_controller_clamped_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .meas_i (meas_if),
    .res_o  (res_if)
  );

  pid_control_checker pid_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .meas      (meas_if),
    .res       (res_if),
    .pending_o (pending_n),
    .errors_o  (errors_n),
    .results_o (results_n),
    .steady_o  (steady_n),
    .clamped_o (clamped_n)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial begin
    #40ms;
    $display("tb_pid_controller_clamped_top: done, errors");
    $finish;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // corner words: zero, one, both signed rails, all ones, or anything
  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // uniform value in [-mag, mag]
  function automatic longint signed_span(int unsigned mag);
    return longint'($urandom_range(0, 2 * mag)) - longint'(mag);
  endfunction

  // next measurement: mostly close to the set point so the loop actually
  // regulates, some wild values, some corners, some repeats (zero derivative)
  function automatic q16_t pick_measure(q16_t last);
    int unsigned roll;
    longint      v;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      v = longint'(target_now) + signed_span(32'd1 << $urandom_range(0, 24));
      if (v > Q_HI) v = Q_HI;
      if (v < Q_LO) v = Q_LO;
      return q16_t'(v);
    end
    if (roll < 75) return q16_t'($urandom);
    if (roll < 85) return q16_t'(corner_word());
    return last;
  endfunction

  // load all eight registers back to back; write enable stays high across them
  task automatic write_setting();
    for (int k = 0; k < 8; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(k);
      cfg_data_i <= reg_word[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    target_now = q16_t'(reg_word[REG_SET_POINT]);
    settings_used++;
  endtask

  task automatic set_all(input logic [31:0] sp, input logic [31:0] kp,
                         input logic [31:0] ki, input logic [31:0] kd,
                         input logic [31:0] lo, input logic [31:0] hi,
                         input logic [31:0] step, input logic [31:0] tol);
    reg_word[REG_SET_POINT] = sp;
    reg_word[REG_GAIN_P]    = kp;
    reg_word[REG_GAIN_I]    = ki;
    reg_word[REG_GAIN_D]    = kd;
    reg_word[REG_OUT_MIN]   = lo;
    reg_word[REG_OUT_MAX]   = hi;
    reg_word[REG_PERIOD]    = step;
    reg_word[REG_TOLERANCE] = tol;
    write_setting();
  endtask

  // one measurement transfer; valid is left high so back-to-back items
  // never lower and raise it within one step
  task automatic send_measure(input q16_t value);
    int unsigned idle;
    idle = no_meas_gaps ? 0 : gap_len();
    if (idle != 0) begin
      meas_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    meas_if.valid    <= 1'b1;
    meas_if.measured <= value;
    @(posedge clk_i);
    while (!meas_if.ready) @(posedge clk_i);
    measures_sent++;
  endtask

  // close a batch: drop valid, wait for every result, then let the block go idle
  task automatic settle();
    meas_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_n != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: random stalls, most short, a few long, none in quiet phases
  initial begin
    int unsigned hold;
    int unsigned burst;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = no_res_stalls ? 0 : gap_len();
      repeat (hold) begin
        @(posedge clk_i);
        res_if.ready <= 1'b0;
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned count;
    int unsigned span;
    q16_t        prev;

    // every input known from time zero
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_SET_POINT;
    cfg_data_i       <= '0;
    meas_if.valid    <= 1'b0;
    meas_if.measured <= '0;
    no_meas_gaps     = 1'b0;
    no_res_stalls    = 1'b0;
    measures_sent    = 0;
    settings_used    = 0;
    target_now       = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---

    // register defaults: all gains zero, drive stays at zero
    send_measure(Q16_MAX);
    send_measure(Q16_MIN);
    send_measure('0);
    settle();

    // widest positive error and a full-swing derivative, gains and
    // tolerance at full scale, smallest nonzero time step
    set_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
    send_measure(Q16_MIN);
    send_measure(Q16_MAX);
    send_measure(Q16_MIN);
    settle();

    // widest negative error
    set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
    send_measure(Q16_MAX);
    send_measure(Q16_MIN);
    settle();

    // zero time step: no integration, derivative pinned to a rail unless
    // the error holds still
    set_all(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_measure(32'sh0005_0000);
    send_measure(32'sh0005_0000);
    send_measure(32'shFFFB_0000);
    send_measure('0);
    settle();

    // crossed limits (min 100.0, max -100.0): upper limit is tested first
    set_all(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
            32'h0064_0000, 32'hFF9C_0000, 32'h0001_0000, 32'h0000_0000);
    send_measure(32'shFFFD_0000);
    send_measure(32'sh00C8_0000);
    settle();

    // steady flag right at a tolerance of 1.0, both signs
    set_all(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000);
    send_measure(32'sh0000_FFFF);
    send_measure(32'sh0001_0000);
    send_measure(-32'sh0000_FFFF);
    send_measure(-32'sh0001_0000);
    settle();

    // --- random part: one register setting per phase ---
    while (measures_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      no_meas_gaps  = ($urandom_range(0, 3) == 0);
      no_res_stalls = ($urandom_range(0, 3) == 0);

      // plant-like baseline: moderate gains, realistic steps and limits
      reg_word[REG_SET_POINT] = 32'(signed_span(32'd1 << 26));
      reg_word[REG_GAIN_P]    = $urandom_range(0, 32'd1 << 19);
      reg_word[REG_GAIN_I]    = $urandom_range(0, 32'd1 << 19);
      reg_word[REG_GAIN_D]    = $urandom_range(0, 32'd1 << 19);
      span = $urandom_range(32'd1 << 16, 32'd1 << 30);
      reg_word[REG_OUT_MIN]   = 32'(-longint'(span));
      reg_word[REG_OUT_MAX]   = $urandom_range(32'd1 << 16, 32'd1 << 30);
      case ($urandom_range(0, 4))
        0: reg_word[REG_PERIOD] = 32'd66;
        1: reg_word[REG_PERIOD] = 32'd655;
        2: reg_word[REG_PERIOD] = 32'd6554;
        3: reg_word[REG_PERIOD] = 32'd65536;
        default: reg_word[REG_PERIOD] = $urandom_range(1, 32'd1 << 17);
      endcase
      reg_word[REG_TOLERANCE] = $urandom_range(0, 32'd1 << 20);

      case (kind)
        5, 6: begin
          // corner values in every register
          for (int k = 0; k < 8; k++) reg_word[k] = corner_word();
        end
        7: begin
          // crossed limits
          if ($urandom_range(0, 3) == 0) begin
            reg_word[REG_OUT_MIN] = 32'h7FFF_FFFF;
            reg_word[REG_OUT_MAX] = 32'h8000_0000;
          end else begin
            reg_word[REG_OUT_MIN] = $urandom_range(0, 32'd1 << 28);
            reg_word[REG_OUT_MAX] = 32'(-longint'($urandom_range(1, 32'd1 << 28)));
          end
        end
        8: begin
          // zero time step, sometimes hidden behind the ignored top bit
          reg_word[REG_PERIOD] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
        end
        9: begin
          // any word at all, including bits above the register widths
          for (int k = 0; k < 8; k++) reg_word[k] = $urandom;
        end
        default: ;
      endcase
      write_setting();

      count = $urandom_range(10, 60);
      prev = target_now;
      repeat (count) begin
        prev = pick_measure(prev);
        send_measure(prev);
      end
      settle();
    end

    $display("covered %0d measurements over %0d register settings: %0d results checked,",
             measures_sent, settings_used, results_n);
    $display("  %0d with steady set, %0d with the drive held at a limit",
             steady_n, clamped_n);
    if (errors_n == 0 && pending_n == 0) begin
      $display("tb_pid_controller_clamped_top: done, clean");
    end else begin
      $display("tb_pid_controller_clamped_top: done, errors");
    end
    $finish;
  end

endmodule
